// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of aclk, inactive while reset is low.
`define YUVB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Concurrent check that is also evaluated while reset is held.
`define YUVB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// File: rtl/yuvb_pkg.sv
// Package: types, widths and constant conversion tables of the YUV 4:2:0 to BGRA core.
package yuvb_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int PIXEL_W   = 32;
    localparam int IN_W      = 10 * SAMPLE_W;
    localparam int OUT_W     = 4 * PIXEL_W;
    localparam int TERM_W    = 9;   // chroma terms span -226..225
    localparam int SUM_W     = 10;  // luma + term spans -226..480
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes on the configuration port
    localparam logic REG_LUMA_SCALE   = 1'b0;
    localparam logic REG_ALPHA_SOURCE = 1'b1;

    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [SAMPLE_W-1:0]      sample_t;
    typedef term_t   term_tab_t [256];
    typedef sample_t chan_tab_t [256];

    // Chroma terms, truncated toward zero; index is the raw sample (128 neutral)
    function automatic term_tab_t build_red_tab();
        term_tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = term_t'((419 * (i - 128)) / 299);
        end
        return t;
    endfunction

    function automatic term_tab_t build_green_cr_tab();
        term_tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = term_t'((-299 * (i - 128)) / 419);
        end
        return t;
    endfunction

    function automatic term_tab_t build_green_cb_tab();
        term_tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = term_t'((-114 * (i - 128)) / 331);
        end
        return t;
    endfunction

    function automatic term_tab_t build_blue_tab();
        term_tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = term_t'((587 * (i - 128)) / 331);
        end
        return t;
    endfunction

    // Limited range expansion: index is v-16, valid for 0..219
    function automatic chan_tab_t build_limited_tab();
        chan_tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = (i <= 219) ? sample_t'((i * 255) / 219) : sample_t'(255);
        end
        return t;
    endfunction

    localparam term_tab_t RED_TAB      = build_red_tab();
    localparam term_tab_t GREEN_CR_TAB = build_green_cr_tab();
    localparam term_tab_t GREEN_CB_TAB = build_green_cb_tab();
    localparam term_tab_t BLUE_TAB     = build_blue_tab();
    localparam chan_tab_t LIMITED_TAB  = build_limited_tab();

endpackage

// File: rtl/yuv420_block_to_bgra_core.sv
// Top level: converts one 2x2 YUV 4:2:0 block with alpha into four BGRA pixels.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  s_      | in        | s_tvalid / s_tready | s_tdata 80 bits: luma x4, Cb, Cr, alpha x4
//  m_      | out       | m_tvalid / m_tready | m_tdata 128 bits: four B,G,R,A pixels
//  apb     | in        | psel/penable/pready | luma_scale @0x0, alpha_source @0x4
//
// One item per cycle sustained while m_tready is held high; m_tvalid rises once an
// accepted item has passed the stage one registers and the result register.
// Stage one looks up the chroma terms in constant tables, stage two maps each
// channel and registers the pixels. A stall on m_tready holds both stages, and
// s_tready drops only when both stages are full.
// aresetn is synchronous, active low; it empties the pipeline and clears both registers.
`include "assert_macros.svh"

module yuv420_block_to_bgra_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] luma_top_left, [15:8] luma_top_right, [23:16] luma_bottom_left,
    // [31:24] luma_bottom_right, [39:32] chroma_blue, [47:40] chroma_red,
    // [55:48] alpha_top_left, [63:56] alpha_top_right,
    // [71:64] alpha_bottom_left, [79:72] alpha_bottom_right
    input  logic [yuvb_pkg::IN_W-1:0]           s_tdata,
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] pixel_top_left, [63:32] pixel_top_right,
    // [95:64] pixel_bottom_left, [127:96] pixel_bottom_right
    output logic [yuvb_pkg::OUT_W-1:0]          m_tdata,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [yuvb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [yuvb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [yuvb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    // Configuration registers
    logic luma_scale_reg, luma_scale_next;
    logic alpha_source_reg, alpha_source_next;
    logic cfg_write;
    logic cfg_index;

    // Stage one: samples and chroma terms
    logic                    s1_valid_reg, s1_valid_next;
    yuvb_pkg::sample_t       s1_luma_reg   [4];
    yuvb_pkg::sample_t       s1_alpha_reg  [4];
    yuvb_pkg::term_t         s1_red_reg, s1_green_reg, s1_blue_reg;
    yuvb_pkg::term_t         red_term, green_term, blue_term;
    yuvb_pkg::sample_t       in_cb, in_cr;

    // Stage two: result register
    logic                        m_valid_reg, m_valid_next;
    logic [yuvb_pkg::OUT_W-1:0]  m_data_reg, m_data_next;

    logic s2_advance;
    logic s1_advance;

    // Map one channel sum to 8 bits under the range mode
    function automatic yuvb_pkg::sample_t map_channel(yuvb_pkg::sum_t v, logic limited);
        yuvb_pkg::sum_t    diff;
        yuvb_pkg::sample_t res;
        diff = v - yuvb_pkg::sum_t'(16);
        if (!limited) begin
            if (v < 0)                              res = '0;
            else if (v > yuvb_pkg::sum_t'(255))     res = '1;
            else                                    res = v[7:0];
        end else begin
            if (v < yuvb_pkg::sum_t'(16))           res = '0;
            else if (v > yuvb_pkg::sum_t'(235))     res = '1;
            else                                    res = yuvb_pkg::LIMITED_TAB[diff[7:0]];
        end
        return res;
    endfunction

    // APB: always ready, register selected by word address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[2];

    always_comb begin
        luma_scale_next   = luma_scale_reg;
        alpha_source_next = alpha_source_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                yuvb_pkg::REG_LUMA_SCALE:   luma_scale_next   = pwdata[0];
                yuvb_pkg::REG_ALPHA_SOURCE: alpha_source_next = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            yuvb_pkg::REG_LUMA_SCALE:   prdata = {31'b0, luma_scale_reg};
            yuvb_pkg::REG_ALPHA_SOURCE: prdata = {31'b0, alpha_source_reg};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            luma_scale_reg   <= 1'b0;
            alpha_source_reg <= 1'b0;
        end else begin
            luma_scale_reg   <= luma_scale_next;
            alpha_source_reg <= alpha_source_next;
        end
    end

    // Pipeline flow control
    assign s2_advance = !m_valid_reg || m_tready;
    assign s1_advance = !s1_valid_reg || s2_advance;
    assign s_tready   = s1_advance;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;

    // Stage one: chroma term lookup
    assign in_cb      = s_tdata[39:32];
    assign in_cr      = s_tdata[47:40];
    assign red_term   = yuvb_pkg::RED_TAB[in_cr];
    assign green_term = yuvb_pkg::GREEN_CR_TAB[in_cr] + yuvb_pkg::GREEN_CB_TAB[in_cb];
    assign blue_term  = yuvb_pkg::BLUE_TAB[in_cb];

    assign s1_valid_next = s1_advance ? s_tvalid : s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s_tvalid) begin
            for (int k = 0; k < 4; k++) begin
                s1_luma_reg[k]  <= s_tdata[8*k +: 8];
                s1_alpha_reg[k] <= s_tdata[48 + 8*k +: 8];
            end
            s1_red_reg   <= red_term;
            s1_green_reg <= green_term;
            s1_blue_reg  <= blue_term;
        end
    end

    // Stage two: add luma, map range, pack B,G,R,A
    always_comb begin
        yuvb_pkg::sum_t    y;
        yuvb_pkg::sample_t a;
        m_data_next = '0;
        for (int k = 0; k < 4; k++) begin
            y = yuvb_pkg::sum_t'({2'b00, s1_luma_reg[k]});
            a = alpha_source_reg ? s1_alpha_reg[k] : 8'hFF;
            m_data_next[32*k +: 32] = {
                a,
                map_channel(y + yuvb_pkg::sum_t'(s1_red_reg),   luma_scale_reg),
                map_channel(y + yuvb_pkg::sum_t'(s1_green_reg), luma_scale_reg),
                map_channel(y + yuvb_pkg::sum_t'(s1_blue_reg),  luma_scale_reg)
            };
        end
    end

    assign m_valid_next = s2_advance ? s1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_advance && s1_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    // Checks
    `YUVB_ASSERT(a_s1_holds_on_stall,
        s1_valid_reg && !s2_advance |=> s1_valid_reg,
        "stage one item lost during stall")
    `YUVB_ASSERT(a_s1_moves_to_out,
        s1_valid_reg && s2_advance |=> m_valid_reg,
        "stage one item did not reach the result register")
    `YUVB_ASSERT(a_ready_when_s1_empty,
        !s1_valid_reg |-> s_tready,
        "input stalled with stage one empty")
    `YUVB_ASSERT(a_cfg_only_on_write,
        !$stable(luma_scale_reg) |-> $past(cfg_write),
        "luma_scale changed without a write")

endmodule
